// File: hdl/ert_pkg.sv
// ---------------------------------------------------------------------------
// ert_pkg
// Shared types and codes for the echo request tracker.
// ---------------------------------------------------------------------------
package ert_pkg;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] ST_TRACKED   = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_MATCHED   = 3'd2;
  localparam logic [2:0] ST_UNMATCHED = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;
  localparam logic [2:0] ST_TICK      = 3'd5;

  localparam logic [15:0] MIN_MSG_LEN   = 16'd8;
  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

  // config register byte addresses
  localparam logic [1:0] REG_TIMEOUT = 2'd0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] peer_ip;
    logic [15:0] ident;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] msg_len;
    logic [31:0] time_ms;
  } req_t;

  typedef struct packed {
    logic [31:0] peer;
    logic [15:0] ident;
    logic [31:0] sent_time;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [31:0] rtt_ms;
    logic [7:0]  expired_mask;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SEND = 3'b010,
    S_SCAN = 3'b100
  } state_t;

endpackage

// File: hdl/echo_request_tracker.sv
// ---------------------------------------------------------------------------
// echo_request_tracker
// Table of outstanding echo requests with reply matching and timeout sweep.
// ---------------------------------------------------------------------------
// Order: a send checks one valid bit per cycle, lowest slot first, until a free
//   slot or the last slot; a reply or a tick runs the one-read-per-cycle scan, a
//   reply ending at its first match; an ignored item is answered from idle.
// One item at a time: busy is high until its done strobe.
// Reset: synchronous rst clears all valid bits, sets timeout_ms to 5000 and
//   drops any item in flight. Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
module echo_request_tracker #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] peer_ip,
  input  logic [15:0] ident,
  input  logic [7:0]  msg_type,
  input  logic [7:0]  msg_code,
  input  logic [15:0] msg_len,
  input  logic [31:0] time_ms,
  // result side, one-cycle strobe
  output logic        done,
  output logic [2:0]  status,
  output logic [2:0]  slot,
  output logic [31:0] rtt_ms,
  output logic [7:0]  expired_mask,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [31:0]      timeout_ms;
  ert_pkg::req_t    req;
  ert_pkg::result_t result;

  logic             mem_wr_en;
  logic [IW-1:0]    mem_wr_addr;
  ert_pkg::entry_t  mem_wr_data;
  logic             mem_rd_en;
  logic [IW-1:0]    mem_rd_addr;
  ert_pkg::entry_t  mem_rd_data;

  // --- config register: written on the access phase of an APB write
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= ert_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr == ert_pkg::REG_TIMEOUT) begin
      timeout_ms <= pwdata;
    end
  end

  assign prdata = (paddr == ert_pkg::REG_TIMEOUT) ? timeout_ms : 32'd0;

  // --- command item; the sequencer latches it when idle
  assign req = '{cmd: cmd, peer_ip: peer_ip, ident: ident, msg_type: msg_type,
                 msg_code: msg_code, msg_len: msg_len, time_ms: time_ms};

  ert_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .timeout_ms  (timeout_ms),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // --- slot table; valid bits stay in the sequencer so reset is instant
  ert_slot_mem #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // --- result fields, held in registers inside the sequencer
  assign status       = result.status;
  assign slot         = result.slot;
  assign rtt_ms       = result.rtt_ms;
  assign expired_mask = result.expired_mask;

endmodule

// File: hdl/ert_slot_mem.sv
// ---------------------------------------------------------------------------
// ert_slot_mem
// Slot table: peer, identifier and send time, one write and one read port,
// read data registered.
// ---------------------------------------------------------------------------
module ert_slot_mem #(
  parameter int SLOTS = 8,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  ert_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output ert_pkg::entry_t rd_data
);

  ert_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/ert_ctrl.sv
// ---------------------------------------------------------------------------
// ert_ctrl
// Command sequencer: valid bits, slot scan over the table memory, result.
// ---------------------------------------------------------------------------
module ert_ctrl #(
  parameter int SLOTS = 8,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CW    = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ert_pkg::req_t    req,
  input  logic [31:0]      timeout_ms,
  output logic             busy,
  output logic             done,
  output ert_pkg::result_t result,
  output logic             mem_wr_en,
  output logic [IW-1:0]    mem_wr_addr,
  output ert_pkg::entry_t  mem_wr_data,
  output logic             mem_rd_en,
  output logic [IW-1:0]    mem_rd_addr,
  input  ert_pkg::entry_t  mem_rd_data
);

  ert_pkg::state_t  state, state_next;
  logic [SLOTS-1:0] valid, valid_next;
  logic [CW-1:0]    idx, idx_next;
  logic             pend, pend_next;
  logic [IW-1:0]    pidx, pidx_next;
  logic [7:0]       mask, mask_next;
  ert_pkg::req_t    cur, cur_next;
  logic             done_next;
  ert_pkg::result_t result_next;

  logic [IW-1:0] idx_ix;
  logic [31:0]   age;
  logic          hit;
  logic          scan_end;

  assign idx_ix   = idx[IW-1:0];
  assign age      = cur.time_ms - mem_rd_data.sent_time;
  assign hit      = pend && valid[pidx];
  assign scan_end = !pend && (idx == CW'(SLOTS));
  assign busy     = (state != ert_pkg::S_IDLE);

  assign mem_wr_addr = idx_ix;
  assign mem_wr_data = '{peer: cur.peer_ip, ident: cur.ident, sent_time: cur.time_ms};
  assign mem_rd_addr = idx_ix;

  always_comb begin
    state_next  = state;
    valid_next  = valid;
    idx_next    = idx;
    pend_next   = 1'b0;
    pidx_next   = pidx;
    mask_next   = mask;
    cur_next    = cur;
    done_next   = 1'b0;
    result_next = result;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;

    unique case (state)
      ert_pkg::S_IDLE: begin
        if (start) begin
          cur_next  = req;
          idx_next  = '0;
          mask_next = '0;
          priority if (req.cmd == ert_pkg::CMD_SEND) begin
            state_next = ert_pkg::S_SEND;
          end else if (req.cmd == ert_pkg::CMD_TICK) begin
            state_next = ert_pkg::S_SCAN;
          end else if (req.cmd == ert_pkg::CMD_RECV && req.msg_len >= ert_pkg::MIN_MSG_LEN &&
                       req.msg_type == 8'd0 && req.msg_code == 8'd0) begin
            state_next = ert_pkg::S_SCAN;
          end else begin
            done_next   = 1'b1;
            result_next = '{status: ert_pkg::ST_IGNORED, slot: 3'd0, rtt_ms: 32'd0,
                            expired_mask: 8'd0};
          end
        end
      end

      // one valid bit per cycle, lowest free slot wins
      ert_pkg::S_SEND: begin
        if (!valid[idx_ix]) begin
          mem_wr_en          = 1'b1;
          valid_next[idx_ix] = 1'b1;
          done_next          = 1'b1;
          result_next        = '{status: ert_pkg::ST_TRACKED, slot: 3'(idx), rtt_ms: 32'd0,
                                 expired_mask: 8'd0};
          state_next         = ert_pkg::S_IDLE;
        end else if (idx == CW'(SLOTS - 1)) begin
          done_next   = 1'b1;
          result_next = '{status: ert_pkg::ST_FULL, slot: 3'd0, rtt_ms: 32'd0,
                          expired_mask: 8'd0};
          state_next  = ert_pkg::S_IDLE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      // read of slot idx issued while slot pidx is compared
      ert_pkg::S_SCAN: begin
        if (idx != CW'(SLOTS)) begin
          mem_rd_en = 1'b1;
          idx_next  = idx + CW'(1);
          pend_next = 1'b1;
          pidx_next = idx_ix;
        end
        if (cur.cmd == ert_pkg::CMD_RECV) begin
          if (hit && mem_rd_data.peer == cur.peer_ip && mem_rd_data.ident == cur.ident) begin
            valid_next[pidx] = 1'b0;
            done_next        = 1'b1;
            result_next      = '{status: ert_pkg::ST_MATCHED, slot: 3'(pidx), rtt_ms: age,
                                 expired_mask: 8'd0};
            state_next       = ert_pkg::S_IDLE;
          end else if (scan_end) begin
            done_next   = 1'b1;
            result_next = '{status: ert_pkg::ST_UNMATCHED, slot: 3'd0, rtt_ms: 32'd0,
                            expired_mask: 8'd0};
            state_next  = ert_pkg::S_IDLE;
          end
        end else begin
          if (hit && age > timeout_ms) begin
            valid_next[pidx] = 1'b0;
            mask_next        = mask | (8'd1 << pidx);  // slots above 7 shift out
          end
          if (scan_end) begin
            done_next   = 1'b1;
            result_next = '{status: ert_pkg::ST_TICK, slot: 3'd0, rtt_ms: 32'd0,
                            expired_mask: mask};
            state_next  = ert_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = ert_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ert_pkg::S_IDLE;
      valid <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      done  <= done_next;
      pend  <= pend_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    pidx   <= pidx_next;
    mask   <= mask_next;
    cur    <= cur_next;
    result <= result_next;
  end

endmodule

// File: hdl/ert_checker.sv
// ---------------------------------------------------------------------------
// ert_checker
// Port-level checks for the echo request tracker, bound to the top level.
// ---------------------------------------------------------------------------
module ert_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [2:0]  slot,
  input logic [31:0] rtt_ms,
  input logic [7:0]  expired_mask
);

  // accepted item raises busy, or an ignored item answers at once
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither raised busy nor gave a result");

  // busy ends only with a result
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (busy || done))
    else $error("busy dropped without a result");

  // a result always closes a busy period, except ignored items
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    (done && status != ert_pkg::ST_IGNORED) |-> $past(busy))
    else $error("result without a busy period");

  // round-trip time only on a matched reply
  a_rtt_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ert_pkg::ST_MATCHED) |-> (rtt_ms == 32'd0))
    else $error("rtt_ms nonzero on a non-matched result");

  // mask only on a tick, slot only on tracked or matched
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ert_pkg::ST_TICK) |->
      (expired_mask == 8'd0 &&
       (slot == 3'd0 || status == ert_pkg::ST_TRACKED || status == ert_pkg::ST_MATCHED)))
    else $error("field set that does not belong to the status");

endmodule

bind echo_request_tracker ert_checker u_ert_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .slot         (slot),
  .rtt_ms       (rtt_ms),
  .expired_mask (expired_mask)
);

// File: tb/echo_request_tracker_tb.sv
// ---------------------------------------------------------------------------
// echo_request_tracker_tb
// Self-checking bench for the echo request tracker: an in-bench slot table
// predicts every result, directed items hit the corner cases, then random
// phases run under several timeout settings, most with random start gaps.
// ---------------------------------------------------------------------------
module echo_request_tracker_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int PHASE_ITEMS = 250;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] ECHO_REPLY = 8'd0;
  localparam logic [7:0] CODE_NONE = 8'd0;

  // DUT inputs start at known values
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = '0;
  logic [31:0] peer_ip = '0;
  logic [15:0] ident = '0;
  logic [7:0]  msg_type = '0;
  logic [7:0]  msg_code = '0;
  logic [15:0] msg_len = '0;
  logic [31:0] time_ms = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [31:0] rtt_ms;
  logic [7:0]  expired_mask;
  logic [31:0] prdata;
  logic        pready;

  echo_request_tracker #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .cmd(cmd), .peer_ip(peer_ip), .ident(ident), .msg_type(msg_type),
    .msg_code(msg_code), .msg_len(msg_len), .time_ms(time_ms),
    .done(done), .status(status), .slot(slot), .rtt_ms(rtt_ms),
    .expired_mask(expired_mask),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Shadow request table: valid bits, entries and the timeout setting
  // -------------------------------------------------------------------------
  logic            req_live [SLOTS];
  ert_pkg::entry_t req_entry [SLOTS];
  logic [31:0]     timeout_setting;

  ert_pkg::req_t    pending_q [$];    // items not yet driven
  ert_pkg::result_t outcome_q [$];    // predicted results, oldest first
  int               mismatches = 0;
  logic             burst = 1'b0;     // no start gaps while set
  int               gap_left = 0;
  ert_pkg::req_t    drive_item;

  // Stimulus generator state
  logic [31:0]   gen_now = '0;
  ert_pkg::req_t sent_log [$];  // recent sends, source of matching replies

  // Next result of the tracker for one item; updates the shadow table.
  function automatic ert_pkg::result_t track_outcome(ert_pkg::req_t rq);
    ert_pkg::result_t r;
    logic        hit;
    logic [31:0] age;
    r = '0;
    hit = 1'b0;
    case (rq.cmd)
      ert_pkg::CMD_SEND: begin
        r.status = ert_pkg::ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && !req_live[i]) begin
            hit = 1'b1;
            req_live[i] = 1'b1;
            req_entry[i].peer = rq.peer_ip;
            req_entry[i].ident = rq.ident;
            req_entry[i].sent_time = rq.time_ms;
            r.status = ert_pkg::ST_TRACKED;
            r.slot = 3'(i);
          end
        end
      end
      ert_pkg::CMD_RECV: begin
        if (rq.msg_len < ert_pkg::MIN_MSG_LEN || rq.msg_type != ECHO_REPLY ||
            rq.msg_code != CODE_NONE) begin
          r.status = ert_pkg::ST_IGNORED;
        end else begin
          r.status = ert_pkg::ST_UNMATCHED;
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && req_live[i] && req_entry[i].peer == rq.peer_ip &&
                req_entry[i].ident == rq.ident) begin
              hit = 1'b1;
              req_live[i] = 1'b0;
              r.status = ert_pkg::ST_MATCHED;
              r.slot = 3'(i);
              r.rtt_ms = rq.time_ms - req_entry[i].sent_time;
            end
          end
        end
      end
      ert_pkg::CMD_TICK: begin
        r.status = ert_pkg::ST_TICK;
        for (int i = 0; i < SLOTS; i++) begin
          age = rq.time_ms - req_entry[i].sent_time;  // wraps mod 2^32
          if (req_live[i] && age > timeout_setting) begin
            req_live[i] = 1'b0;
            if (i < 8) r.expired_mask[i] = 1'b1;
          end
        end
      end
      default: r.status = ert_pkg::ST_IGNORED;
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Driver: start is held until accepted, so every item driven will be
  // accepted in order; its result is predicted as it goes out.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      // item accepted at this edge: draw the gap before the next one
      if (start) gap_left = burst ? 0 : $urandom_range(0, 9);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        drive_item = pending_q.pop_front();
        outcome_q.push_back(track_outcome(drive_item));
        cmd      <= drive_item.cmd;
        peer_ip  <= drive_item.peer_ip;
        ident    <= drive_item.ident;
        msg_type <= drive_item.msg_type;
        msg_code <= drive_item.msg_code;
        msg_len  <= drive_item.msg_len;
        time_ms  <= drive_item.time_ms;
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: done is a one-cycle strobe, sampled at the edge ending it
  // -------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ert_pkg::result_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $display("%0t ns: result expected none got status %0d slot %0d rtt %0h mask %0h",
                 $time, status, slot, rtt_ms, expired_mask);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("slot", 32'(want.slot), 32'(slot));
        check_field("rtt_ms", want.rtt_ms, rtt_ms);
        check_field("expired_mask", 32'(want.expired_mask), 32'(expired_mask));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic add_item(input logic [1:0] c, input logic [31:0] peer,
                          input logic [15:0] id, input logic [7:0] ty,
                          input logic [7:0] co, input logic [15:0] len,
                          input logic [31:0] t);
    ert_pkg::req_t it;
    it.cmd = c;
    it.peer_ip = peer;
    it.ident = id;
    it.msg_type = ty;
    it.msg_code = co;
    it.msg_len = len;
    it.time_ms = t;
    pending_q.push_back(it);
  endtask

  // fields the command does not use still get random values
  function automatic ert_pkg::req_t noise_item(input logic [1:0] c);
    ert_pkg::req_t it;
    it.cmd = c;
    it.peer_ip = $urandom();
    it.ident = 16'($urandom());
    it.msg_type = 8'($urandom());
    it.msg_code = 8'($urandom());
    it.msg_len = 16'($urandom());
    it.time_ms = gen_now;
    return it;
  endfunction

  task automatic queue_random(input int n);
    ert_pkg::req_t it;
    int   roll;
    int   pick;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 3) gen_now = $urandom();
      else gen_now += $urandom_range(0, 600);
      pick = (sent_log.size() > 0) ? $urandom_range(0, sent_log.size() - 1) : 0;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        it = noise_item(ert_pkg::CMD_SEND);
        // repeat a recent peer/ident now and then
        if (sent_log.size() > 0 && $urandom_range(0, 3) == 0) begin
          it.peer_ip = sent_log[pick].peer_ip;
          it.ident = sent_log[pick].ident;
        end
        sent_log.push_back(it);
        if (sent_log.size() > SLOTS) void'(sent_log.pop_front());
      end else if (roll < 65) begin
        // well-formed echo reply, mostly for a recent request
        it = noise_item(ert_pkg::CMD_RECV);
        it.msg_type = ECHO_REPLY;
        it.msg_code = CODE_NONE;
        it.msg_len = 16'($urandom_range(int'(ert_pkg::MIN_MSG_LEN), 65535));
        if (sent_log.size() > 0 && $urandom_range(0, 3) != 0) begin
          it.peer_ip = sent_log[pick].peer_ip;
          it.ident = sent_log[pick].ident;
        end
      end else if (roll < 75) begin
        // broken reply: exactly one reason to drop it, or random junk
        it = noise_item(ert_pkg::CMD_RECV);
        if (sent_log.size() > 0) begin
          it.peer_ip = sent_log[pick].peer_ip;
          it.ident = sent_log[pick].ident;
        end
        case ($urandom_range(0, 3))
          0: begin
            it.msg_len = 16'($urandom_range(0, int'(ert_pkg::MIN_MSG_LEN) - 1));
            it.msg_type = ECHO_REPLY;
            it.msg_code = CODE_NONE;
          end
          1: begin
            it.msg_type = 8'($urandom_range(1, 255));
            it.msg_code = CODE_NONE;
            it.msg_len = 16'($urandom_range(int'(ert_pkg::MIN_MSG_LEN), 65535));
          end
          2: begin
            it.msg_type = ECHO_REPLY;
            it.msg_code = 8'($urandom_range(1, 255));
            it.msg_len = 16'($urandom_range(int'(ert_pkg::MIN_MSG_LEN), 65535));
          end
          default: ;
        endcase
      end else if (roll < 95) begin
        it = noise_item(ert_pkg::CMD_TICK);
        // land on the expiry boundary of a recent request
        if (sent_log.size() > 0 && $urandom_range(0, 4) == 0) begin
          gen_now = sent_log[pick].time_ms + timeout_setting + $urandom_range(0, 1);
          it.time_ms = gen_now;
        end
      end else begin
        it = noise_item(CMD_UNUSED);
      end
      pending_q.push_back(it);
    end
  endtask

  // wait until every item is out and every result is back
  task automatic drain();
    while (pending_q.size() > 0 || start || outcome_q.size() > 0 || busy)
      @(posedge clk);
  endtask

  // APB write to the timeout register, only with the tracker idle
  task automatic write_timeout(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ert_pkg::REG_TIMEOUT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    timeout_setting = value;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  logic [31:0] phase_timeout [8] = '{32'd0, 32'd1, ert_pkg::TIMEOUT_RESET, 32'd300,
                                     32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd2000};

  initial begin
    timeout_setting = ert_pkg::TIMEOUT_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      req_live[i] = 1'b0;
      req_entry[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset timeout of 5000
    // empty tick, then a reply with nothing to match
    add_item(ert_pkg::CMD_TICK, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 32'd100);
    add_item(ert_pkg::CMD_RECV, 32'h1, 16'h1, ECHO_REPLY, CODE_NONE, 16'd8, 32'd100);
    add_item(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(ert_pkg::CMD_SEND, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 32'd0);
    add_item(ert_pkg::CMD_SEND, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
             32'hFFFF_FFFF);
    add_item(ert_pkg::CMD_SEND, 32'h0A00_0001, 16'h1234, 8'h0, 8'h0, 16'd8,
             32'hFFFF_F000);
    // duplicate
    add_item(ert_pkg::CMD_SEND, 32'h0A00_0001, 16'h1234, 8'h0, 8'h0, 16'd8, 32'd10);
    add_item(ert_pkg::CMD_SEND, 32'hC0A8_0001, 16'h0001, 8'h0, 8'h0, 16'd0,
             32'hFFFF_FFFF);
    add_item(ert_pkg::CMD_SEND, 32'hC0A8_0002, 16'h0002, 8'h0, 8'h0, 16'd0, 32'd100);
    add_item(ert_pkg::CMD_SEND, 32'hC0A8_0003, 16'h0003, 8'h0, 8'h0, 16'd0, 32'd200);
    add_item(ert_pkg::CMD_SEND, 32'hC0A8_0004, 16'h0004, 8'h0, 8'h0, 16'd0, 32'd300);
    // table full
    add_item(ert_pkg::CMD_SEND, 32'h5555_AAAA, 16'hAAAA, 8'h0, 8'h0, 16'd0, 32'd300);
    // replies dropped for length, type and code
    add_item(ert_pkg::CMD_RECV, 32'h0A00_0001, 16'h1234, ECHO_REPLY, CODE_NONE, 16'd7,
             32'h10);
    add_item(ert_pkg::CMD_RECV, 32'h0A00_0001, 16'h1234, 8'd8, CODE_NONE, 16'd64,
             32'h10);
    add_item(ert_pkg::CMD_RECV, 32'h0A00_0001, 16'h1234, ECHO_REPLY, 8'd1, 16'd64,
             32'h10);
    // lowest of the two duplicates first, rtt wraps past zero
    add_item(ert_pkg::CMD_RECV, 32'h0A00_0001, 16'h1234, ECHO_REPLY, CODE_NONE,
             16'hFFFF, 32'h10);
    add_item(ert_pkg::CMD_RECV, 32'h0A00_0001, 16'h1234, ECHO_REPLY, CODE_NONE, 16'd8,
             32'h10);
    add_item(ert_pkg::CMD_RECV, 32'h0A00_0001, 16'h1234, ECHO_REPLY, CODE_NONE, 16'd8,
             32'h10);
    add_item(ert_pkg::CMD_RECV, 32'hFFFF_FFFF, 16'hFFFF, ECHO_REPLY, CODE_NONE, 16'd8,
             32'd5);
    // age equal to the timeout stays, one more expires
    add_item(ert_pkg::CMD_TICK, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 32'd5000);
    add_item(ert_pkg::CMD_TICK, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 32'd5001);
    drain();

    // zero timeout: age 0 survives, age 1 expires
    write_timeout(32'd0);
    add_item(ert_pkg::CMD_SEND, 32'h1234_5678, 16'h00FF, 8'h0, 8'h0, 16'h0, 32'd777);
    add_item(ert_pkg::CMD_TICK, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 32'd777);
    add_item(ert_pkg::CMD_TICK, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 32'd778);
    drain();

    // random phases, one timeout setting each
    phase_timeout[6] = $urandom();
    for (int ph = 0; ph < 8; ph++) begin
      write_timeout(phase_timeout[ph]);
      burst = (ph % 3 == 1);
      if (ph == 4) gen_now = 32'hFFFF_F000;  // run across the time wrap
      queue_random(PHASE_ITEMS);
      drain();
    end

    repeat (SLOTS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
